// File: rtl/b64_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions for the base64 codec.
// ----------------------------------------------------------------------------
package b64_pkg;

    // mode register codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // pad character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // command queue geometry
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // one command: up to four result bytes from one input transaction
    typedef struct packed {
        logic [3:0][7:0] data;      // result bytes, entry 0 first
        logic [1:0]      top;       // index of the final byte (count - 1)
        logic            has_byte;  // low only for the empty end marker
        logic            last;      // final byte closes the buffer
    } t_cmd;

    // 6-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // character to value: bit 6 set marks a character outside the alphabet
    function automatic logic [6:0] dec_value(input logic [7:0] c);
        logic [6:0] v;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 7'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            v = 7'd62;
        end else if (c == 8'h2F) begin
            v = 7'd63;
        end else begin
            v = 7'd64;
        end
        return v;
    endfunction

endpackage

// File: rtl/b64_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_front
// Accepts input bytes, tracks group phase and bit accumulator, and turns
// each transaction that yields output into one command of up to four result bytes.
// ----------------------------------------------------------------------------
module b64_front import b64_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_data,
    input  logic       i_push,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_in,
    input  logic       i_q_full,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    logic        r_mode;
    logic [1:0]  r_phase;
    logic [23:0] r_acc;
    logic [1:0]  n_phase;
    logic [23:0] n_acc;

    logic            accept;
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
    logic            has;
    logic [6:0]      dv;
    logic [23:0]     acc_v;

    assign accept = i_push && !i_q_full;
    assign dv     = dec_value(i_in_byte);
    assign acc_v  = {r_acc[17:0], dv[5:0]};

    // per-transaction step
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        cnt     = 3'd0;
        bytes   = '0;
        has     = 1'b1;
        if (r_mode == MODE_ENCODE) begin
            unique case (r_phase)
                2'd0: begin
                    bytes[0] = enc_char(i_in_byte[7:2]);
                    cnt      = 3'd1;
                    if (i_last_in) begin
                        bytes[1] = enc_char({i_in_byte[1:0], 4'b0000});
                        bytes[2] = PAD_CHAR;
                        bytes[3] = PAD_CHAR;
                        cnt      = 3'd4;
                    end
                    n_acc   = {16'd0, i_in_byte};
                    n_phase = 2'd1;
                end
                2'd1: begin
                    bytes[0] = enc_char({r_acc[1:0], i_in_byte[7:4]});
                    cnt      = 3'd1;
                    if (i_last_in) begin
                        bytes[1] = enc_char({i_in_byte[3:0], 2'b00});
                        bytes[2] = PAD_CHAR;
                        cnt      = 3'd3;
                    end
                    n_acc   = {16'd0, i_in_byte};
                    n_phase = 2'd2;
                end
                default: begin
                    bytes[0] = enc_char({r_acc[3:0], i_in_byte[7:6]});
                    bytes[1] = enc_char(i_in_byte[5:0]);
                    cnt      = 3'd2;
                    n_acc    = '0;
                    n_phase  = 2'd0;
                end
            endcase
        end else begin
            // decode: characters outside the alphabet are skipped
            if (!dv[6]) begin
                if (r_phase == 2'd3) begin
                    bytes[0] = acc_v[23:16];
                    bytes[1] = acc_v[15:8];
                    bytes[2] = acc_v[7:0];
                    cnt      = 3'd3;
                    n_phase  = 2'd0;
                    n_acc    = '0;
                end else begin
                    n_phase = r_phase + 2'd1;
                    n_acc   = acc_v;
                end
            end
            // partial group at end of buffer
            if (i_last_in) begin
                if (n_phase == 2'd3) begin
                    bytes[0] = n_acc[17:10];
                    bytes[1] = n_acc[9:2];
                    cnt      = 3'd2;
                end else if (n_phase == 2'd2) begin
                    bytes[0] = n_acc[11:4];
                    cnt      = 3'd1;
                end
            end
        end
        // empty end marker and group reset at end of buffer
        if (i_last_in) begin
            if (cnt == 3'd0) begin
                cnt      = 3'd1;
                bytes[0] = 8'h00;
                has      = 1'b0;
            end
            n_phase = 2'd0;
            n_acc   = '0;
        end
    end

    // command to the queue
    assign o_cmd_push     = accept && (cnt != 3'd0);
    assign o_cmd.data     = bytes;
    assign o_cmd.top      = 2'(cnt - 3'd1);
    assign o_cmd.has_byte = has;
    assign o_cmd.last     = i_last_in;

    // mode and group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENCODE;
            r_phase <= 2'd0;
            r_acc   <= '0;
        end else if (i_cfg_valid) begin
            r_mode  <= i_cfg_data;
            r_phase <= 2'd0;
            r_acc   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

endmodule

// File: rtl/b64_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_cmdq
// Short command queue between front and back, so each side stalls alone.
// ----------------------------------------------------------------------------
module b64_cmdq import b64_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wr_data,
    input  logic i_rd,
    output t_cmd o_rd_data,
    output logic o_full,
    output logic o_empty
);

    t_cmd               r_mem [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wr_ptr;
    logic [CMDQ_AW-1:0] r_rd_ptr;
    logic [CMDQ_CW-1:0] r_count;

    assign o_full    = (r_count == CMDQ_CW'(CMDQ_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= CMDQ_AW'(r_wr_ptr + 1'b1);
            end
            if (i_rd) begin
                r_rd_ptr <= CMDQ_AW'(r_rd_ptr + 1'b1);
            end
            if (i_wr && !i_rd) begin
                r_count <= CMDQ_CW'(r_count + 1'b1);
            end else if (i_rd && !i_wr) begin
                r_count <= CMDQ_CW'(r_count - 1'b1);
            end
        end
    end

    // fill level never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CMDQ_CW'(CMDQ_DEPTH))
        else $error("command queue overfilled");

    // no write while full
    a_no_wr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("command written while queue full");

    // no read while empty
    a_no_rd_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd |-> !o_empty)
        else $error("command read while queue empty");

    // a lone write raises the fill level by one
    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> r_count == CMDQ_CW'($past(r_count) + 1'b1))
        else $error("fill level did not follow a write");

endmodule

// File: rtl/b64_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_back
// Holds one command and hands its bytes out one per result transaction.
// ----------------------------------------------------------------------------
module b64_back import b64_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_q_data,
    output logic       o_q_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_last_out
);

    logic       r_busy;
    t_cmd       r_cmd;
    logic [1:0] r_idx;

    logic at_top;
    logic take;
    logic finish;
    logic load;

    assign at_top = (r_idx == r_cmd.top);
    assign take   = r_busy && i_pop;
    assign finish = take && at_top;
    assign load   = !i_q_empty && (!r_busy || finish);
    assign o_q_rd = load;

    // result ports
    assign o_empty    = !r_busy;
    assign o_out_byte = r_cmd.data[r_idx];
    assign o_has_byte = r_cmd.has_byte;
    assign o_last_out = r_cmd.last && at_top;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (finish) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    // current command
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cmd <= i_q_data;
        end
    end

endmodule

// File: rtl/base64_stream_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming base64 encoder / decoder, standard alphabet, with end marking.
//
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------
// input    | in        | push / full          | i_in_byte, i_last_in
// result   | out       | empty / pop          | o_out_byte, o_has_byte,
//          |           |                      | o_last_out
// config   | in        | i_cfg_valid / ready  | i_cfg_data (mode)
//
// An input transaction is classified in the cycle it is accepted and its
// results (up to four) enter a four-deep command queue; the back end then
// gives one result per cycle while the result side keeps popping. The output
// port sets the rate: encode gives four result bytes per three input bytes.
// Input stalls (full) only when the command queue fills.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module base64_stream_codec import b64_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_last_in,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_has_byte,
    output logic       o_last_out
);

    t_cmd q_wr_data;
    t_cmd q_rd_data;
    logic q_wr;
    logic q_rd;
    logic q_full;
    logic q_empty;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    // front end
    b64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_in_byte  (i_in_byte),
        .i_last_in  (i_last_in),
        .i_q_full   (q_full),
        .o_cmd_push (q_wr),
        .o_cmd      (q_wr_data)
    );

    // command queue
    b64_cmdq u_cmdq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (q_wr),
        .i_wr_data(q_wr_data),
        .i_rd     (q_rd),
        .o_rd_data(q_rd_data),
        .o_full   (q_full),
        .o_empty  (q_empty)
    );

    // back end
    b64_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rd_data),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out_byte(o_out_byte),
        .o_has_byte(o_has_byte),
        .o_last_out(o_last_out)
    );

endmodule
